// ----- hdl/bcs_pkg.sv -----
// bcs_pkg: shared types, constants and the basis table for the b-spline sampler
// no dependencies
package bcs_pkg;

  localparam int unsigned Segments = 20;
  localparam int unsigned JW = 5;      // holds 0..Segments
  localparam int unsigned CW = 24;     // coordinate width
  localparam int unsigned BW = 17;     // Q1.16 basis width
  localparam int unsigned SW = 23;     // spacing width
  localparam int unsigned TblW = 4 * (Segments + 1) * BW;
  localparam logic [SW-1:0] MinSpacingRst = 23'd12800;
  localparam logic CmdPoint = 1'b0;
  localparam logic CmdClear = 1'b1;

  // one queued job: a single segment, a window preload, or a clear
  typedef struct packed {
    logic          clr;
    logic          first;   // sample from j = 0
    logic          last;    // last segment of the item
    logic          shift;   // move the point into the window afterwards
    logic [CW-1:0] px;
    logic [CW-1:0] py;
  } job_t;

  // restoring division, only evaluated on constants while building the table
  function automatic longint unsigned udiv(input longint unsigned n, input longint unsigned d);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // basis values for every k and j, Q1.16 rounded half up
  function automatic logic [TblW-1:0] basis_table();
    longint s, jj, num, den;
    logic [TblW-1:0] t;
    t = '0;
    s = Segments;
    den = 6 * s * s * s;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j <= int'(Segments); j++) begin
        jj = j;
        unique case (k)
          0: num = (s - jj) * (s - jj) * (s - jj);
          1: num = 3 * jj * jj * jj - 6 * jj * jj * s + 4 * s * s * s;
          2: num = -3 * jj * jj * jj + 3 * jj * jj * s + 3 * jj * s * s + s * s * s;
          default: num = jj * jj * jj;
        endcase
        t[(k * (Segments + 1) + j) * BW +: BW] =
          BW'(udiv(longint'(num * 65536 + (den >>> 1)), longint'(den)));
      end
    end
    return t;
  endfunction

  localparam logic [TblW-1:0] BasisTbl = basis_table();

  // basis value k at step j, looked up in the constant table
  function automatic logic [BW-1:0] basis(input logic [1:0] k, input logic [JW-1:0] j);
    logic [6:0] idx;
    idx = 7'(k) * 7'(Segments + 1) + 7'(j);
    basis = BasisTbl[idx * BW +: BW];
  endfunction

endpackage

// ----- hdl/bcs_front.sv -----
// bcs_front: accepts items, tracks curve progress and queues segment jobs
// depends on bcs_pkg
module bcs_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   cmd_i,
  input  logic [bcs_pkg::CW-1:0] in_x_i,
  input  logic [bcs_pkg::CW-1:0] in_y_i,
  input  logic                   is_final_i,
  output logic                   job_valid_o,
  input  logic                   job_ready_i,
  output bcs_pkg::job_t          job_o
);

  // two-entry queue of jobs
  bcs_pkg::job_t q_mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  // segments still to issue for the held item
  logic [1:0]    segs_q;
  bcs_pkg::job_t pend_q;
  logic [1:0]    seen_q;   // 0 idle, 1 first segment next, 2 later

  logic push, pop;
  bcs_pkg::job_t push_job;

  assign in_ready_o  = (segs_q == 2'd0);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem_q[rd_q];
  assign pop         = job_valid_o && job_ready_i;
  assign push        = (segs_q != 2'd0) && (cnt_q != 2'd2 || pop);

  always_comb begin
    push_job      = pend_q;
    push_job.last = (segs_q == 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      cnt_q  <= 2'd0;
      segs_q <= 2'd0;
      seen_q <= 2'd0;
    end else begin
      if (push) begin
        q_mem_q[wr_q] <= push_job;
        wr_q <= ~wr_q;
        segs_q <= segs_q - 2'd1;
        // after the window preload the next segment is still the first one
        if (pend_q.shift) pend_q.first <= 1'b0;
        pend_q.shift <= 1'b1;
      end
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (in_valid_i && in_ready_o) begin
        pend_q.px    <= in_x_i;
        pend_q.py    <= in_y_i;
        pend_q.clr   <= (cmd_i == bcs_pkg::CmdClear);
        pend_q.last  <= 1'b0;
        pend_q.shift <= 1'b1;
        pend_q.first <= (seen_q != 2'd2);
        if (cmd_i == bcs_pkg::CmdClear) begin
          segs_q <= 2'd1;
        end else if (seen_q == 2'd0) begin
          // first point loads the window via a zero-sample preload job
          segs_q <= is_final_i ? 2'd3 : 2'd1;
          pend_q.shift <= 1'b0;
          seen_q <= is_final_i ? 2'd0 : 2'd1;
        end else begin
          segs_q <= is_final_i ? 2'd3 : 2'd1;
          seen_q <= is_final_i ? 2'd0 : 2'd2;
        end
      end
    end
  end

endmodule

// ----- hdl/bcs_back.sv -----
// bcs_back: evaluates one segment per job, a sample at a time, plus spacing check
// depends on bcs_pkg
module bcs_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [bcs_pkg::SW-1:0] min_spacing_i,
  input  logic                   job_valid_i,
  output logic                   job_ready_o,
  input  bcs_pkg::job_t          job_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [bcs_pkg::CW-1:0] out_x_o,
  output logic [bcs_pkg::CW-1:0] out_y_o,
  output logic                   kept_o,
  output logic                   run_end_o
);
  localparam int unsigned CW = bcs_pkg::CW;
  localparam int unsigned PW = 44;   // product sum width
  localparam int unsigned BW_S = bcs_pkg::BW + 1;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_RND, S_CHK, S_OUT} state_e;
  state_e state_q;

  logic signed [CW-1:0] wx_q [3];
  logic signed [CW-1:0] wy_q [3];
  bcs_pkg::job_t        job_q;
  logic [bcs_pkg::JW-1:0] j_q;
  logic [1:0]           k_q;   // basis term being multiplied
  logic signed [PW-1:0] ax_q, ay_q;
  logic signed [PW-1:0] mx_q, my_q;
  logic signed [CW-1:0] sx_q, sy_q, lkx_q, lky_q;
  logic                 have_q;
  logic [2*CW:0]        d2_q, lim_q;
  logic [2*CW-1:0]      dxx_q, dyy_q;
  logic [1:0]           chk_q;

  logic signed [CW-1:0] cx, cy;
  logic signed [BW_S-1:0] bk;
  always_comb begin
    unique case (k_q)
      2'd0: begin cx = wx_q[0]; cy = wy_q[0]; end
      2'd1: begin cx = wx_q[1]; cy = wy_q[1]; end
      2'd2: begin cx = wx_q[2]; cy = wy_q[2]; end
      default: begin cx = job_q.px; cy = job_q.py; end
    endcase
    bk = {1'b0, bcs_pkg::basis(k_q, j_q)};
  end

  // round to nearest, ties up, then saturate
  function automatic logic [CW-1:0] rnd(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = (v + PW'(32768)) >>> 16;
    if (r > PW'(8388607)) rnd = 24'h7fffff;
    else if (r < -PW'(8388608)) rnd = 24'h800000;
    else rnd = r[CW-1:0];
  endfunction

  logic signed [CW:0] dx, dy;
  assign dx = {sx_q[CW-1], sx_q} - {lkx_q[CW-1], lkx_q};
  assign dy = {sy_q[CW-1], sy_q} - {lky_q[CW-1], lky_q};

  assign job_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_x_o     = sx_q;
  assign out_y_o     = sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      have_q  <= 1'b0;
      lkx_q   <= '0;
      lky_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (job_valid_i) begin
          job_q <= job_i;
          if (job_i.clr) begin
            have_q <= 1'b0;
          end else if (!job_i.shift) begin
            // first point of a curve fills the window
            for (int i = 0; i < 3; i++) begin
              wx_q[i] <= job_i.px;
              wy_q[i] <= job_i.py;
            end
            if (job_i.last) begin
              // lone non-final first point: nothing more
            end
          end else begin
            j_q <= job_i.first ? '0 : bcs_pkg::JW'(1);
            k_q <= 2'd0;
            ax_q <= '0;
            ay_q <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          mx_q <= PW'(bk * cx);
          my_q <= PW'(bk * cy);
          state_q <= S_ACC;
        end
        S_ACC: begin
          ax_q <= ax_q + mx_q;
          ay_q <= ay_q + my_q;
          k_q  <= k_q + 2'd1;
          state_q <= (k_q == 2'd3) ? S_RND : S_MUL;
        end
        S_RND: begin
          sx_q <= rnd(ax_q);
          sy_q <= rnd(ay_q);
          chk_q <= 2'd0;
          state_q <= S_CHK;
        end
        S_CHK: begin
          // squares, then sum, then compare
          chk_q <= chk_q + 2'd1;
          unique case (chk_q)
            2'd0: begin
              dxx_q <= (2*CW)'(dx * dx);
              dyy_q <= (2*CW)'(dy * dy);
              lim_q <= (2*CW+1)'(min_spacing_i * min_spacing_i);
            end
            2'd1: d2_q <= {1'b0, dxx_q} + {1'b0, dyy_q};
            default: begin
              kept_o <= !have_q || (d2_q >= lim_q);
              if (!have_q || (d2_q >= lim_q)) begin
                lkx_q <= sx_q; lky_q <= sy_q; have_q <= 1'b1;
              end
              run_end_o <= job_q.last && (j_q == bcs_pkg::JW'(bcs_pkg::Segments));
              state_q <= S_OUT;
            end
          endcase
        end
        S_OUT: if (out_ready_i) begin
          if (j_q == bcs_pkg::JW'(bcs_pkg::Segments)) begin
            wx_q[0] <= wx_q[1]; wx_q[1] <= wx_q[2]; wx_q[2] <= job_q.px;
            wy_q[0] <= wy_q[1]; wy_q[1] <= wy_q[2]; wy_q[2] <= job_q.py;
            state_q <= S_IDLE;
          end else begin
            j_q <= j_q + bcs_pkg::JW'(1);
            k_q <= 2'd0;
            ax_q <= '0;
            ay_q <= '0;
            state_q <= S_MUL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/bspline_curve_sampler.sv -----
// bspline_curve_sampler: top level, front/back pair with a job queue between
// depends on bcs_pkg, bcs_front, bcs_back
// each segment gives 21 or 20 samples (21 when it samples from j = 0), made one at a time
// on a multiplier per axis shared by the four basis terms, then the spacing check;
// the next sample starts only after the output has taken the last one
// reset: asynchronous active low, clears window progress, kept memory; min_spacing = 12800
module bspline_curve_sampler (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [bcs_pkg::SW-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   cmd_i,
  input  logic [bcs_pkg::CW-1:0] in_x_i,
  input  logic [bcs_pkg::CW-1:0] in_y_i,
  input  logic                   is_final_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [bcs_pkg::CW-1:0] out_x_o,
  output logic [bcs_pkg::CW-1:0] out_y_o,
  output logic                   kept_o,
  output logic                   run_end_o
);

  logic [bcs_pkg::SW-1:0] min_spacing_q;
  logic job_valid, job_ready;
  bcs_pkg::job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) min_spacing_q <= bcs_pkg::MinSpacingRst;
    else if (cfg_we_i) min_spacing_q <= cfg_wdata_i;
  end

  bcs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .in_x_i, .in_y_i, .is_final_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  bcs_back u_back (
    .clk_i, .rst_ni, .min_spacing_i(min_spacing_q),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .out_valid_o, .out_ready_i, .out_x_o, .out_y_o, .kept_o, .run_end_o
  );

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o))
    else $error("output beat dropped");
  a_kept_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && job_ready && job.clr |=> !out_valid_o)
    else $error("clear produced a beat");
`endif

endmodule
